[sv/marching_cubes_cell_vertices_top_defines.svh]
// assertion macros for the cell vertex block
`ifndef MARCHING_CUBES_CELL_VERTICES_TOP_DEFINES_SVH
`define MARCHING_CUBES_CELL_VERTICES_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MCV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCV_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCV_ASSERT(label, clk, rst_n, prop, msg)
`define MCV_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[sv/mcv_pkg.sv]
package mcv_pkg;

    localparam int CellBits  = 10;
    localparam int SampBits  = 16;
    localparam int FracBits  = 8;
    localparam int CoordBits = 18;
    localparam int EdgeBits  = 4;
    localparam int CntBits   = 4;
    localparam int MaxVerts  = 15;

    localparam logic [7:0] CornerXSet = 8'h33;
    localparam logic [7:0] CornerYSet = 8'hF0;
    localparam logic [7:0] CornerZSet = 8'h99;

    typedef logic [EdgeBits-1:0] edge_t;

    typedef struct packed {
        logic [CntBits-1:0]         count;
        logic [MaxVerts*EdgeBits-1:0] edges;
    } tri_row_t;

    function automatic tri_row_t tri_lookup(input logic [7:0] idx);
        string s;
        tri_row_t r;
        int n;
        byte c;
        logic [EdgeBits-1:0] e;
        r = '0;
        case (idx)
        8'd0: s = ""; 8'd1: s = "083"; 8'd2: s = "019"; 8'd3: s = "183981";
        8'd4: s = "12a"; 8'd5: s = "08312a"; 8'd6: s = "92a029"; 8'd7: s = "2832a8a98";
        8'd8: s = "3b2"; 8'd9: s = "0b28b0"; 8'd10: s = "19023b"; 8'd11: s = "1b219b98b";
        8'd12: s = "3a1ba3"; 8'd13: s = "0a108a8ba"; 8'd14: s = "3903b9ba9"; 8'd15: s = "98aa8b";
        8'd16: s = "478"; 8'd17: s = "430734"; 8'd18: s = "019847"; 8'd19: s = "419471731";
        8'd20: s = "12a847"; 8'd21: s = "34730412a"; 8'd22: s = "92a902847";
        8'd23: s = "2a9297273794";
        8'd24: s = "8473b2"; 8'd25: s = "b47b24204"; 8'd26: s = "90184723b";
        8'd27: s = "47b94b9b2921";
        8'd28: s = "3a13ba784"; 8'd29: s = "1ba14b1047b4"; 8'd30: s = "47890b9bab03";
        8'd31: s = "47b4b99ba";
        8'd32: s = "954"; 8'd33: s = "954083"; 8'd34: s = "054150"; 8'd35: s = "854835315";
        8'd36: s = "12a954"; 8'd37: s = "30812a495"; 8'd38: s = "52a542402";
        8'd39: s = "2a5325354348";
        8'd40: s = "95423b"; 8'd41: s = "0b208b495"; 8'd42: s = "05401523b";
        8'd43: s = "21525828b485";
        8'd44: s = "a3ba13954"; 8'd45: s = "4950818a18ba"; 8'd46: s = "54050b5bab03";
        8'd47: s = "54858aa8b";
        8'd48: s = "978579"; 8'd49: s = "930953573"; 8'd50: s = "078017157"; 8'd51: s = "153357";
        8'd52: s = "978957a12"; 8'd53: s = "a12950530573"; 8'd54: s = "802825857a52";
        8'd55: s = "2a5253357";
        8'd56: s = "7957893b2"; 8'd57: s = "95797292027b"; 8'd58: s = "23b018178157";
        8'd59: s = "b21b17715";
        8'd60: s = "958857a13a3b"; 8'd61: s = "5705097b010aba0"; 8'd62: s = "ba0b03a50807570";
        8'd63: s = "ba57b5";
        8'd64: s = "a65"; 8'd65: s = "0835a6"; 8'd66: s = "9015a6"; 8'd67: s = "1831985a6";
        8'd68: s = "165261"; 8'd69: s = "165126308"; 8'd70: s = "965906026";
        8'd71: s = "598582526328";
        8'd72: s = "23ba65"; 8'd73: s = "b08b20a65"; 8'd74: s = "01923b5a6";
        8'd75: s = "5a61929b298b";
        8'd76: s = "63b653513"; 8'd77: s = "08b0b50515b6"; 8'd78: s = "3b6036065059";
        8'd79: s = "65969bb98";
        8'd80: s = "5a6478"; 8'd81: s = "43047365a"; 8'd82: s = "1905a6847";
        8'd83: s = "a65197173794";
        8'd84: s = "612651478"; 8'd85: s = "125526304347"; 8'd86: s = "847905065026";
        8'd87: s = "739794329596269";
        8'd88: s = "3b2784a65"; 8'd89: s = "5a647242027b"; 8'd90: s = "01947823b5a6";
        8'd91: s = "9219b294b7b45a6";
        8'd92: s = "8473b53515b6"; 8'd93: s = "51b5b610b7b404b"; 8'd94: s = "059065036b63847";
        8'd95: s = "65969b4797b9";
        8'd96: s = "a4964a"; 8'd97: s = "4a649a083"; 8'd98: s = "a01a60640";
        8'd99: s = "83181686461a";
        8'd100: s = "149124264"; 8'd101: s = "308129249264"; 8'd102: s = "024426";
        8'd103: s = "832824426";
        8'd104: s = "a49a64b23"; 8'd105: s = "08228b49a4a6"; 8'd106: s = "3b201606461a";
        8'd107: s = "64161a48121b8b1";
        8'd108: s = "964936913b63"; 8'd109: s = "8b1810b61914641"; 8'd110: s = "3b6360064";
        8'd111: s = "648b68";
        8'd112: s = "7a678a89a"; 8'd113: s = "0730a709a67a"; 8'd114: s = "a671a7178180";
        8'd115: s = "a67a71173";
        8'd116: s = "126168189867"; 8'd117: s = "269291679093739"; 8'd118: s = "780706602";
        8'd119: s = "732672";
        8'd120: s = "23ba68a89867"; 8'd121: s = "20727b09767a9a7"; 8'd122: s = "1801781a767a23b";
        8'd123: s = "b21b17a61671";
        8'd124: s = "896867916b63136"; 8'd125: s = "091b67"; 8'd126: s = "7807063b0b60";
        8'd127: s = "7b6";
        8'd128: s = "76b"; 8'd129: s = "308b76"; 8'd130: s = "019b76"; 8'd131: s = "819831b76";
        8'd132: s = "a126b7"; 8'd133: s = "12a3086b7"; 8'd134: s = "2902a96b7";
        8'd135: s = "6b72a3a83a98";
        8'd136: s = "723627"; 8'd137: s = "708760620"; 8'd138: s = "276237019";
        8'd139: s = "162186198876";
        8'd140: s = "a76a17137"; 8'd141: s = "a7617a187108"; 8'd142: s = "03707a0a96a7";
        8'd143: s = "76a7a88a9";
        8'd144: s = "684b86"; 8'd145: s = "36b306046"; 8'd146: s = "86b846901";
        8'd147: s = "946963931b36";
        8'd148: s = "6846b82a1"; 8'd149: s = "12a30b06b046"; 8'd150: s = "4b846b0292a9";
        8'd151: s = "a93a32943b36463";
        8'd152: s = "823842462"; 8'd153: s = "042462"; 8'd154: s = "190234246438";
        8'd155: s = "194142246";
        8'd156: s = "8138618466a1"; 8'd157: s = "a10a06604"; 8'd158: s = "4634386a3039a93";
        8'd159: s = "a946a4";
        8'd160: s = "49576b"; 8'd161: s = "083495b76"; 8'd162: s = "50154076b";
        8'd163: s = "b76834354315";
        8'd164: s = "954a1276b"; 8'd165: s = "6b712a083495"; 8'd166: s = "76b54a42a402";
        8'd167: s = "348354325a52b76";
        8'd168: s = "723762549"; 8'd169: s = "954086062687"; 8'd170: s = "362376150540";
        8'd171: s = "628687218485158";
        8'd172: s = "954a16176137"; 8'd173: s = "16a176107870954"; 8'd174: s = "40a4a503a6a737a";
        8'd175: s = "76a7a854a48a";
        8'd176: s = "6956b9b89"; 8'd177: s = "36b063056095"; 8'd178: s = "0b805b01556b";
        8'd179: s = "6b3635531";
        8'd180: s = "12a95b9b8b56"; 8'd181: s = "0b306b09656912a"; 8'd182: s = "b85b56805a52025";
        8'd183: s = "6b36352a3a53";
        8'd184: s = "589528562382"; 8'd185: s = "956960062"; 8'd186: s = "158180568382628";
        8'd187: s = "156216";
        8'd188: s = "13616a386569896"; 8'd189: s = "a10a06950560"; 8'd190: s = "03856a";
        8'd191: s = "a56";
        8'd192: s = "b5a75b"; 8'd193: s = "b5ab75830"; 8'd194: s = "5b75ab190";
        8'd195: s = "a75ab7981831";
        8'd196: s = "b12b71751"; 8'd197: s = "08312717572b"; 8'd198: s = "9759279022b7";
        8'd199: s = "75272b592328982";
        8'd200: s = "25a235375"; 8'd201: s = "820852875a25"; 8'd202: s = "9015a35373a2";
        8'd203: s = "982921872a25752";
        8'd204: s = "135375"; 8'd205: s = "087071175"; 8'd206: s = "903935537";
        8'd207: s = "987597";
        8'd208: s = "5845a8ab8"; 8'd209: s = "5045b05abb30"; 8'd210: s = "01984a8aba45";
        8'd211: s = "ab4a45b34941314";
        8'd212: s = "2512852b8458"; 8'd213: s = "04b0b345b2b151b"; 8'd214: s = "0250592b5458b85";
        8'd215: s = "9452b3";
        8'd216: s = "25a352345384"; 8'd217: s = "5a2524420"; 8'd218: s = "3a235a385458019";
        8'd219: s = "5a2524192942";
        8'd220: s = "845853351"; 8'd221: s = "045105"; 8'd222: s = "845853905035";
        8'd223: s = "945";
        8'd224: s = "4b749b9ab"; 8'd225: s = "0834979b79ab"; 8'd226: s = "1ab1b414074b";
        8'd227: s = "3143481a474bab4";
        8'd228: s = "4b79b492b912"; 8'd229: s = "9749b791b2b1083"; 8'd230: s = "b74b42240";
        8'd231: s = "b74b42834324";
        8'd232: s = "29a279237749"; 8'd233: s = "9a7974a27870207"; 8'd234: s = "37a3a274a1a040a";
        8'd235: s = "1a2874";
        8'd236: s = "491417713"; 8'd237: s = "491417081871"; 8'd238: s = "403743";
        8'd239: s = "487";
        8'd240: s = "9a8ab8"; 8'd241: s = "30939bb9a"; 8'd242: s = "01a0a88ab";
        8'd243: s = "31ab3a";
        8'd244: s = "12b1b99b8"; 8'd245: s = "30939b1292b9"; 8'd246: s = "02b80b";
        8'd247: s = "32b";
        8'd248: s = "23828aa89"; 8'd249: s = "9a2092"; 8'd250: s = "23828a0181a8";
        8'd251: s = "1a2";
        8'd252: s = "138918"; 8'd253: s = "091"; 8'd254: s = "038";
        default: s = "";
        endcase
        n = s.len();
        for (int k = 0; k < MaxVerts; k++)
        begin
            if (k < n)
            begin
                c = s.getc(k);
                if (c >= "0" && c <= "9")
                    e = EdgeBits'(c - "0");
                else if (c == "a")
                    e = 4'd10;
                else
                    e = 4'd11;
                r.edges[k*EdgeBits +: EdgeBits] = e;
            end
        end
        r.count = CntBits'(n);
        return r;
    endfunction

    function automatic logic [2:0] corner_a(input edge_t e);
        if (e < 4'd8)
            return e[2:0];
        else
            return {1'b0, e[1:0]};
    endfunction

    function automatic logic [2:0] corner_b(input edge_t e);
        if (e < 4'd4)
            return {1'b0, 2'(e[1:0] + 2'd1)};
        else if (e < 4'd8)
            return {1'b1, 2'(e[1:0] + 2'd1)};
        else
            return {1'b1, e[1:0]};
    endfunction

endpackage

[sv/marching_cubes_cell_vertices_top.sv]
// Marching-cubes vertex generator. One transaction on s_axis carries a cell's eight
// corner samples and its coordinates; the block classifies the corners against the
// threshold, looks up the triangle-table row and sends one m_axis transaction per
// edge vertex (0 to 15 per cell, tlast on the last). A cell occupies the input for a
// classification step, then issues one vertex per cycle while credit allows; the edge
// sequencer pauses while 31 vertices are in flight or queued, so a slow m_axis
// consumer holds the cell longer. The first vertex of a cell reaches m_axis through
// classification, corner select, operand stage, the interpolation divider with its
// input register and one stage per fraction bit, coordinate stage and the output
// queue.
`include "marching_cubes_cell_vertices_top_defines.svh"
module marching_cubes_cell_vertices_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // corner_0..corner_7 (16 each), cell_x, cell_y, cell_z (10 each), zero pad
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_x, vertex_y, vertex_z (18 each), edge_number (4), zero pad
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import mcv_pkg::*;

    localparam int SB     = SampBits;
    localparam int NumW   = SB + 1 + FracBits;
    localparam int DenW   = SB + 1;
    localparam int FifoD  = 32;
    localparam int FifoAw = 5;

    logic signed [SB-1:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // output queue with credit so the pipeline never needs to stall
    logic [FifoAw:0]   inflight_reg, inflight_next;
    logic [FifoAw:0]   fcnt_reg;
    logic [FifoAw-1:0] wp_reg, rp_reg;
    logic [58:0]       fmem [FifoD];
    logic [58:0]       fhead_reg;
    logic              fhead_vld_reg;

    // stage A: cell register and sequencer
    logic              a_busy_reg;
    logic [159:0]      a_data_reg;
    logic [7:0]        a_idx_reg;
    logic              a_cls_reg;
    tri_row_t          a_row_reg;
    logic [CntBits-1:0] a_pos_reg;
    logic [7:0]        idx_c;
    logic              issue;
    logic              a_done;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            idx_c[i] = ($signed(s_axis_tdata[i*SB +: SB]) >= thr_reg);
    end

    logic credit_ok;
    assign credit_ok     = (inflight_reg < (FifoAw+1)'(FifoD - 1));
    assign issue         = a_busy_reg && !a_cls_reg && (a_pos_reg < a_row_reg.count)
                           && credit_ok;
    assign a_done        = a_busy_reg && !a_cls_reg &&
                           ((a_row_reg.count == '0) ||
                            (issue && (a_pos_reg == a_row_reg.count - 1'b1)));
    assign s_axis_tready = !a_busy_reg || a_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_busy_reg <= 1'b0;
            a_cls_reg  <= 1'b0;
            a_pos_reg  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                a_busy_reg <= 1'b1;
                a_cls_reg  <= 1'b1;
                a_pos_reg  <= '0;
            end
            else if (a_done)
                a_busy_reg <= 1'b0;
            else if (a_cls_reg)
                a_cls_reg <= 1'b0;
            else if (issue)
                a_pos_reg <= a_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            a_data_reg <= s_axis_tdata;
            a_idx_reg  <= idx_c;
        end
        if (a_cls_reg)
            a_row_reg <= tri_lookup(a_idx_reg);
    end

    // stage B: corner selection
    logic               b_vld_reg;
    edge_t              b_edge_reg;
    logic               b_last_reg;
    logic signed [SB-1:0] b_va_reg, b_vb_reg;
    logic [2:0]         b_a_reg, b_b_reg;
    logic [29:0]        b_cell_reg;
    edge_t              e_c;
    logic [2:0]         ca_c, cb_c;

    assign e_c  = a_row_reg.edges[a_pos_reg*EdgeBits +: EdgeBits];
    assign ca_c = corner_a(e_c);
    assign cb_c = corner_b(e_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        b_edge_reg <= e_c;
        b_last_reg <= (a_pos_reg == a_row_reg.count - 1'b1);
        b_va_reg   <= a_data_reg[ca_c*SB +: SB];
        b_vb_reg   <= a_data_reg[cb_c*SB +: SB];
        b_a_reg    <= ca_c;
        b_b_reg    <= cb_c;
        b_cell_reg <= a_data_reg[8*SB +: 30];
    end

    // stage C: numerator and denominator
    logic               c_vld_reg;
    logic [NumW-1:0]    c_num_reg;
    logic [DenW-1:0]    c_den_reg;
    logic               c_zero_reg;
    logic [39:0]        c_tag_reg;
    logic signed [SB+1:0] num_s, den_s;
    logic [SB+1:0]      num_m, den_m;
    logic               pos_c;

    always_comb
    begin
        num_s = (SB+2)'(thr_reg) - (SB+2)'(b_va_reg);
        den_s = (SB+2)'(b_vb_reg) - (SB+2)'(b_va_reg);
        if (den_s < 0)
        begin
            den_m = (SB+2)'(-den_s);
            num_m = (SB+2)'(-num_s);
        end
        else
        begin
            den_m = den_s;
            num_m = num_s;
        end
        pos_c = (den_m != '0) && !num_m[SB+1] && (num_m != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        c_num_reg  <= {num_m[SB:0], {FracBits{1'b0}}};
        c_den_reg  <= pos_c ? den_m[SB:0] : DenW'(1);
        c_zero_reg <= !pos_c;
        c_tag_reg  <= {b_cell_reg, b_a_reg, b_b_reg, b_edge_reg};
    end

    // stage D: divider
    logic                     d_vld;
    logic [FracBits-1:0]      d_q;
    logic [40:0]              d_tag;
    logic [NumW-1:0]          d_num;

    assign d_num = c_zero_reg ? '0 : c_num_reg;

    mcv_divider #(
        .NumBits(NumW), .DenBits(DenW), .QBits(FracBits), .TagBits(41)
    ) u_div (
        .clk(clk), .rst_n(rst_n), .en(1'b1),
        .in_valid(c_vld_reg), .num(d_num >> FracBits), .den(c_den_reg),
        .in_tag({(c_num_reg[NumW-1:FracBits] >= c_den_reg) && !c_zero_reg,
                 c_tag_reg}),
        .out_valid(d_vld), .quo(d_q), .out_tag(d_tag)
    );

    // stage E: coordinates
    logic                     e_vld_reg;
    logic [58:0]              e_word_reg;
    logic [FracBits-1:0]      t_c;
    logic [29:0]              cell_d;
    logic [2:0]               ea, eb;
    logic [CoordBits-1:0]     px, py, pz;

    function automatic logic [CoordBits-1:0] axis(input logic [CellBits-1:0] cidx,
                                                    input logic [7:0] set,
                                                    input logic [2:0] a,
                                                    input logic [2:0] b,
                                                    input logic [FracBits-1:0] t);
        logic [CoordBits+1:0] base, p;
        base = (CoordBits+2)'(cidx) << FracBits;
        if (set[a] == set[b])
            p = base + (set[a] ? (CoordBits+2)'(1) << FracBits : '0);
        else if (!set[a])
            p = base + (CoordBits+2)'(t);
        else
            p = base + ((CoordBits+2)'(1) << FracBits) - (CoordBits+2)'(t);
        return (p > (CoordBits+2)'({CoordBits{1'b1}})) ? {CoordBits{1'b1}} :
               p[CoordBits-1:0];
    endfunction

    assign t_c    = d_tag[40] ? {FracBits{1'b1}} : d_q;
    assign cell_d = d_tag[39:10];
    assign ea     = d_tag[9:7];
    assign eb     = d_tag[6:4];
    assign px     = axis(cell_d[9:0], CornerXSet, ea, eb, t_c);
    assign py     = axis(cell_d[19:10], CornerYSet, ea, eb, t_c);
    assign pz     = axis(cell_d[29:20], CornerZSet, ea, eb, t_c);

    // last flag travels beside the pipeline
    logic [FracBits+1:0] last_sr_reg;
    always_ff @(posedge clk)
        last_sr_reg <= {last_sr_reg[FracBits:0], b_last_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
        e_word_reg <= {last_sr_reg[FracBits+1], d_tag[3:0], pz, py, px};

    // output queue
    logic fpop, fload;
    assign fpop  = m_axis_tvalid && m_axis_tready;
    assign fload = (fcnt_reg != '0) && (!fhead_vld_reg || fpop);

    always_comb
    begin
        inflight_next = inflight_reg + (FifoAw+1)'(issue) - (FifoAw+1)'(fpop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg  <= '0;
            fcnt_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fhead_vld_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            fcnt_reg     <= fcnt_reg + (FifoAw+1)'(e_vld_reg) - (FifoAw+1)'(fload);
            if (e_vld_reg)
                wp_reg <= wp_reg + 1'b1;
            if (fload)
            begin
                rp_reg        <= rp_reg + 1'b1;
                fhead_vld_reg <= 1'b1;
            end
            else if (fpop)
                fhead_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_vld_reg)
            fmem[wp_reg] <= e_word_reg;
        if (fload)
            fhead_reg <= fmem[rp_reg];
    end

    assign m_axis_tvalid = fhead_vld_reg;
    assign m_axis_tdata  = {6'd0, fhead_reg[57:0]};
    assign m_axis_tlast  = fhead_reg[58];

    `MCV_ASSERT(a_credit, clk, rst_n, inflight_reg <= (FifoAw+1)'(FifoD), "credit overrun")
    `MCV_ASSERT(a_fifo, clk, rst_n, !(e_vld_reg && fcnt_reg == (FifoAw+1)'(FifoD)), "queue overflow")
    `MCV_ASSERT(a_seq, clk, rst_n, issue |-> !(s_axis_tvalid && s_axis_tready && !a_done), "issue while loading")
endmodule

[sv/mcv_divider.sv]
module mcv_divider #(
    parameter int NumBits = 24,
    parameter int DenBits = 17,
    parameter int QBits   = 8,
    parameter int TagBits = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NumBits-1:0] num,
    input  logic [DenBits-1:0] den,
    input  logic [TagBits-1:0] in_tag,
    output logic               out_valid,
    output logic [QBits-1:0]   quo,
    output logic [TagBits-1:0] out_tag
);
    // restoring divider, one quotient bit per stage, numerator = x << QBits
    localparam int RemBits = DenBits + 1;

    logic [QBits:0]              vld_reg;
    logic [RemBits-1:0]          rem_reg  [QBits+1];
    logic [DenBits-1:0]          den_reg  [QBits+1];
    logic [QBits-1:0]            q_reg    [QBits+1];
    logic [TagBits-1:0]          tag_reg  [QBits+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QBits-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RemBits'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < QBits; k++)
            begin
                logic [RemBits:0] sh;
                sh = {rem_reg[k], 1'b0};
                if (sh >= {1'b0, 1'b0, den_reg[k]})
                begin
                    rem_reg[k+1] <= RemBits'(sh - {2'b00, den_reg[k]});
                    q_reg[k+1]   <= {q_reg[k][QBits-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= RemBits'(sh);
                    q_reg[k+1]   <= {q_reg[k][QBits-2:0], 1'b0};
                end
                den_reg[k+1] <= den_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QBits];
    assign quo       = q_reg[QBits];
    assign out_tag   = tag_reg[QBits];
endmodule
